// ===== src/rmna_pkg.sv =====
package rmna_pkg;

  localparam int FIELD_BITS = 32;
  localparam int WIDE_BITS  = 128;
  localparam int MAG_BITS   = 64;

  localparam logic [2:0] FUNC_NORM = 3'd0;
  localparam logic [2:0] FUNC_ADD  = 3'd1;
  localparam logic [2:0] FUNC_SUB  = 3'd2;
  localparam logic [2:0] FUNC_MUL  = 3'd3;
  localparam logic [2:0] FUNC_DIV  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // classified job handed from the front to the back
  typedef struct packed {
    logic                    err;
    logic [2:0]              func;
    logic                    a_neg;
    logic                    b_neg;
    logic [FIELD_BITS-1:0]   a_whole;
    logic [FIELD_BITS-1:0]   a_numer;
    logic [FIELD_BITS-1:0]   a_denom;
    logic [FIELD_BITS-1:0]   b_whole;
    logic [FIELD_BITS-1:0]   b_numer;
    logic [FIELD_BITS-1:0]   b_denom;
  } job_t;

endpackage

// ===== src/rmna_front.sv =====
module rmna_front
  import rmna_pkg::*;
#(
  parameter int RES_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid,
  output logic                  stall,
  input  logic [2:0]            func,
  input  logic                  a_negative,
  input  logic [FIELD_BITS-1:0] a_whole,
  input  logic [FIELD_BITS-1:0] a_numer,
  input  logic [FIELD_BITS-1:0] a_denom,
  input  logic                  b_negative,
  input  logic [FIELD_BITS-1:0] b_whole,
  input  logic [FIELD_BITS-1:0] b_numer,
  input  logic [FIELD_BITS-1:0] b_denom,
  output logic                  q_valid,
  input  logic                  q_take,
  output job_t                  q_job
);

  localparam logic [FIELD_BITS-1:0] MASK =
    FIELD_BITS'((65'd1 << RES_BITS) - 65'd1);

  // two-entry queue
  job_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  job_t       job;
  logic [2:0] f;
  logic       acc;

  always_comb begin
    f = (func > FUNC_DIV) ? FUNC_NORM : func;
    job.func    = f;
    job.a_neg   = a_negative;
    job.b_neg   = b_negative;
    job.a_whole = a_whole & MASK;
    job.a_numer = a_numer & MASK;
    job.a_denom = a_denom & MASK;
    job.b_whole = b_whole & MASK;
    job.b_numer = b_numer & MASK;
    job.b_denom = b_denom & MASK;
    job.err = (job.a_denom == '0) || (f != FUNC_NORM && job.b_denom == '0) ||
              (f == FUNC_DIV && job.b_whole == '0 && job.b_numer == '0);
  end

  assign stall   = (cnt == 2'd2);
  assign acc     = valid && !stall;
  assign q_valid = (cnt != 2'd0);
  assign q_job   = mem[rp];

  always_ff @(posedge clk) begin
    if (acc) begin
      mem[wp] <= job;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (acc) wp <= ~wp;
      if (q_take && q_valid) rp <= ~rp;
      cnt <= cnt + {1'b0, acc} - {1'b0, q_take && q_valid};
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !(q_take && q_valid)) |=> cnt == 2'd2)
    else $error("full queue lost an entry");
  assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 && !acc) |=> !q_valid)
    else $error("empty queue shows valid");

endmodule

// ===== src/rmna_back.sv =====
module rmna_back
  import rmna_pkg::*;
#(
  parameter int RES_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_take,
  input  job_t                  q_job,
  output logic                  valid,
  input  logic                  stall,
  output logic                  r_negative,
  output logic [FIELD_BITS-1:0] r_whole,
  output logic [FIELD_BITS-1:0] r_numer,
  output logic [FIELD_BITS-1:0] r_denom,
  output logic [1:0]            status
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_M1   = 5'd1;   // a whole*denom product
  localparam logic [4:0] S_M2   = 5'd2;   // a magnitude, b whole*denom product
  localparam logic [4:0] S_M3   = 5'd3;   // b magnitude
  localparam logic [4:0] S_M4   = 5'd4;
  localparam logic [4:0] S_M5   = 5'd5;
  localparam logic [4:0] S_M6   = 5'd6;
  localparam logic [4:0] S_COMB = 5'd7;
  localparam logic [4:0] S_G0   = 5'd8;
  localparam logic [4:0] S_G1   = 5'd9;
  localparam logic [4:0] S_G2   = 5'd10;
  localparam logic [4:0] S_G3   = 5'd11;
  localparam logic [4:0] S_G4   = 5'd12;
  localparam logic [4:0] S_D1   = 5'd13;
  localparam logic [4:0] S_D2   = 5'd14;
  localparam logic [4:0] S_D3   = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  localparam logic [WIDE_BITS-1:0] LIM = WIDE_BITS'((129'd1 << RES_BITS) - 129'd1);

  logic [4:0]            state;
  job_t                  j;
  logic [MAG_BITS-1:0]   amag, bmag;
  logic [WIDE_BITS-1:0]  x, y, n, d, ga, gb, g;
  logic [7:0]            k;
  logic                  neg;
  logic [1:0]            mstep;
  // 64x64 product built from 32x32 partial products, one per cycle
  logic [MAG_BITS-1:0]   ma, mb;
  logic [WIDE_BITS-1:0]  macc;
  logic [1:0]            mi;
  // shared restoring divider
  logic [WIDE_BITS-1:0]  dn, dd, dq, dr;
  logic [7:0]            di;
  logic [WIDE_BITS-1:0]  rsh;
  logic                  rcar;
  logic [WIDE_BITS-1:0]  qn;

  logic [63:0]           pp;
  logic [31:0]           pa, pb;

  always_comb begin
    pa = mi[0] ? ma[63:32] : ma[31:0];
    pb = mi[1] ? mb[63:32] : mb[31:0];
    pp = pa * pb;
    rcar = dr[WIDE_BITS-1];
    rsh  = {dr[WIDE_BITS-2:0], dn[di[6:0]]};
    qn = dq;
    if (rcar || rsh >= dd) qn[di[6:0]] = 1'b1;
  end

  // a new job only once the result register is free
  assign q_take = (state == S_IDLE) && q_valid && !valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      if (valid && !stall) valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_take) begin
            j <= q_job;
            state <= q_job.err ? S_OUT : S_M1;
            if (q_job.err) begin
              r_negative <= 1'b0; r_whole <= '0; r_numer <= '0; r_denom <= '0;
              status <= ST_DIV0;
            end
          end
        end
        S_M1: begin
          amag <= MAG_BITS'(j.a_whole) * MAG_BITS'(j.a_denom);
          state <= S_M2;
        end
        S_M2: begin
          bmag <= MAG_BITS'(j.b_whole) * MAG_BITS'(j.b_denom);
          amag <= amag + MAG_BITS'(j.a_numer);
          state <= S_M3;
        end
        S_M3: begin
          bmag <= bmag + MAG_BITS'(j.b_numer);
          mstep <= 2'd0;
          state <= S_M4;
        end
        S_M4: begin
          // choose operands for the next wide product
          case (j.func)
            FUNC_NORM: begin
              x <= WIDE_BITS'(amag); y <= '0; d <= WIDE_BITS'(j.a_denom);
              state <= S_COMB;
            end
            default: begin
              case (mstep)
                2'd0: begin
                  ma <= amag;
                  mb <= (j.func == FUNC_MUL) ? bmag : MAG_BITS'(j.b_denom);
                end
                2'd1: begin
                  ma <= (j.func == FUNC_MUL) ? MAG_BITS'(j.a_denom) : bmag;
                  mb <= (j.func == FUNC_MUL) ? MAG_BITS'(j.b_denom)
                                             : MAG_BITS'(j.a_denom);
                end
                default: begin
                  ma <= MAG_BITS'(j.a_denom); mb <= MAG_BITS'(j.b_denom);
                end
              endcase
              macc <= '0;
              mi <= 2'd0;
              state <= S_M5;
            end
          endcase
        end
        S_M5: begin
          macc <= macc + (WIDE_BITS'(pp) << {({1'b0, mi[0]} + {1'b0, mi[1]}), 5'd0});
          mi <= mi + 2'd1;
          if (mi == 2'd3) state <= S_M6;
        end
        S_M6: begin
          case (mstep)
            2'd0: x <= macc;
            2'd1: y <= macc;
            default: d <= macc;
          endcase
          if (mstep == 2'd2 || (mstep == 2'd1 && j.func != FUNC_ADD
                                && j.func != FUNC_SUB)) begin
            if (mstep == 2'd1) d <= macc;
            state <= S_COMB;
          end else begin
            mstep <= mstep + 2'd1;
            state <= S_M4;
          end
        end
        S_COMB: begin
          // x/y hold numerator and cross term; for mul/div y is the denominator
          if (j.func == FUNC_ADD || j.func == FUNC_SUB) begin
            if (j.a_neg == (j.b_neg ^ (j.func == FUNC_SUB))) begin
              n <= x + y; neg <= j.a_neg && (x + y != '0);
            end else if (x >= y) begin
              n <= x - y; neg <= j.a_neg && (x != y);
            end else begin
              n <= y - x; neg <= j.b_neg ^ (j.func == FUNC_SUB);
            end
          end else if (j.func == FUNC_NORM) begin
            n <= x; neg <= j.a_neg;
          end else begin
            n <= x; neg <= j.a_neg ^ j.b_neg;
          end
          state <= S_G0;
        end
        S_G0: begin
          ga <= n; gb <= d; k <= '0;
          state <= S_G1;
        end
        S_G1: begin
          // binary gcd, one step a cycle
          if (ga == '0) begin g <= gb; state <= S_D1; end
          else if (ga[0] == 1'b0 && gb[0] == 1'b0) begin
            ga <= ga >> 1; gb <= gb >> 1; k <= k + 8'd1;
          end else state <= S_G2;
        end
        S_G2: begin
          if (ga[0] == 1'b0) ga <= ga >> 1;
          else state <= S_G3;
        end
        S_G3: begin
          if (gb == '0) begin g <= ga; state <= S_G4; end
          else if (gb[0] == 1'b0) gb <= gb >> 1;
          else if (ga > gb) begin ga <= gb; gb <= ga - gb; end
          else gb <= gb - ga;
        end
        S_G4: begin
          if (k != '0) begin g <= g << 1; k <= k - 8'd1; end
          else state <= S_D1;
        end
        S_D1: begin
          dn <= n; dd <= g; dq <= '0; dr <= '0; di <= 8'd127; mstep <= 2'd0;
          state <= S_D2;
        end
        S_D2: begin
          // restoring division, one quotient bit a cycle
          if (rcar || rsh >= dd) dr <= rsh - dd;
          else dr <= rsh;
          dq <= qn;
          if (di == 8'd0) state <= S_D3;
          else di <= di - 8'd1;
        end
        S_D3: begin
          case (mstep)
            2'd0: begin
              n <= dq; dn <= d; dd <= g; mstep <= 2'd1;
              dq <= '0; dr <= '0; di <= 8'd127; state <= S_D2;
            end
            2'd1: begin
              d <= dq; dn <= n; dd <= dq; mstep <= 2'd2;
              dq <= '0; dr <= '0; di <= 8'd127; state <= S_D2;
            end
            default: begin
              if (dq > LIM || d > LIM) begin
                r_negative <= 1'b0; r_whole <= '0; r_numer <= '0; r_denom <= '0;
                status <= ST_OVF;
              end else begin
                r_negative <= neg;
                r_whole <= dq[FIELD_BITS-1:0];
                r_numer <= dr[FIELD_BITS-1:0];
                r_denom <= d[FIELD_BITS-1:0];
                status <= ST_OK;
              end
              state <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (!valid || !stall) begin
            valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (valid && stall) |=> valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst)
    q_take |-> state == S_IDLE)
    else $error("job taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    (valid && status == ST_OK) |-> (r_numer < r_denom))
    else $error("fraction not proper");

endmodule

// ===== src/rational_mixed_number_alu_top.sv =====
// Rational mixed-number ALU: normalise, add, subtract, multiply, divide.
// Three 128-bit restoring divisions run at one quotient bit a cycle; the wide
// products are built from 32x32 product slices, and the binary gcd adds a step
// per shift or subtract. Divide by zero skips the arithmetic and goes straight
// to the result stage.
// One transaction in the back at a time; the next starts once the result has
// left. A two-entry queue lets the front accept while the back is busy.
// Reset (rst, synchronous, active high) empties the queue and the result stage.
module rational_mixed_number_alu_top
  import rmna_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            func,
  input  logic                  a_negative,
  input  logic [FIELD_BITS-1:0] a_whole,
  input  logic [FIELD_BITS-1:0] a_numer,
  input  logic [FIELD_BITS-1:0] a_denom,
  input  logic                  b_negative,
  input  logic [FIELD_BITS-1:0] b_whole,
  input  logic [FIELD_BITS-1:0] b_numer,
  input  logic [FIELD_BITS-1:0] b_denom,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  r_negative,
  output logic [FIELD_BITS-1:0] r_whole,
  output logic [FIELD_BITS-1:0] r_numer,
  output logic [FIELD_BITS-1:0] r_denom,
  output logic [1:0]            status
);

  // result word is capped at the field width
  localparam int RES_BITS = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;

  logic q_valid;
  logic q_take;
  job_t q_job;

  // front: masks operands, flags divide-by-zero, queues the transaction
  rmna_front #(.RES_BITS(RES_BITS)) u_front (
    .clk, .rst, .valid(in_valid), .stall(in_stall),
    .func, .a_negative, .a_whole, .a_numer, .a_denom,
    .b_negative, .b_whole, .b_numer, .b_denom,
    .q_valid, .q_take, .q_job
  );

  // back: wide products, gcd reduction, split into whole and fraction
  rmna_back #(.RES_BITS(RES_BITS)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_job,
    .valid(out_valid), .stall(out_stall),
    .r_negative, .r_whole, .r_numer, .r_denom, .status
  );

endmodule

// ===== tb/tb.sv =====
module tb
  import rmna_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // one operation as offered on the input channel
  typedef struct packed {
    logic [2:0]            f;
    logic                  an;
    logic [FIELD_BITS-1:0] aw, ai, ad;
    logic                  bn;
    logic [FIELD_BITS-1:0] bw, bi, bd;
  } op_t;

  // one result as it leaves the block
  typedef struct packed {
    logic                  neg;
    logic [FIELD_BITS-1:0] whl, num, den;
    logic [1:0]            st;
  } res_t;

  // directed row: the operation, and a typed answer where it is obvious
  typedef struct {
    op_t  op;
    bit   typed;
    res_t ans;
  } row_t;

  localparam int HOLD_CYCLES = 3000;  // long receiver hold-off
  localparam int WD_LIMIT    = 20000; // cycles with no transaction at all
  localparam int N_RANDOM    = 1835;
  localparam int N_CALM      = 150;   // final stretch with no idling
  localparam logic [31:0] MAXW = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] func = FUNC_NORM;
  logic a_negative = 1'b0, b_negative = 1'b0;
  logic [FIELD_BITS-1:0] a_whole = '0, a_numer = '0, a_denom = '0;
  logic [FIELD_BITS-1:0] b_whole = '0, b_numer = '0, b_denom = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic r_negative;
  logic [FIELD_BITS-1:0] r_whole, r_numer, r_denom;
  logic [1:0] status;

  res_t results_due[$];   // expected results, oldest first
  int   fails = 0;
  int   idle_cycles = 0;
  bit   calm = 1'b0;      // no idling on either side
  bit   hold_req = 1'b0;  // ask the receiver for one long hold-off

  always #5 clk = ~clk;

  rational_mixed_number_alu_top #(.WORD_BITS(32)) uut (.*);

  // Exact rational arithmetic at 128 bits: cross-multiply, reduce by Euclid,
  // split into whole part and proper fraction.
  function automatic res_t rational_result(op_t o);
    logic [127:0] amag, bmag, x, y, n, d, p, q, t, whl;
    logic [2:0] f;
    logic neg, ys;
    res_t r;
    r = '0;
    f = (o.f > FUNC_DIV) ? FUNC_NORM : o.f;
    if (o.ad == 0 || (f != FUNC_NORM && o.bd == 0) ||
        (f == FUNC_DIV && o.bw == 0 && o.bi == 0)) begin
      r.st = ST_DIV0;
      return r;
    end
    amag = 128'(o.aw) * 128'(o.ad) + 128'(o.ai);
    bmag = 128'(o.bw) * 128'(o.bd) + 128'(o.bi);
    case (f)
      FUNC_ADD, FUNC_SUB: begin
        x  = amag * 128'(o.bd);
        y  = bmag * 128'(o.ad);
        ys = (f == FUNC_SUB) ? ~o.bn : o.bn;
        if (o.an == ys) begin
          n = x + y; neg = o.an;
        end else if (x >= y) begin
          n = x - y; neg = o.an;
        end else begin
          n = y - x; neg = ys;
        end
        if (n == 0) neg = 1'b0;   // zero sum is always positive
        d = 128'(o.ad) * 128'(o.bd);
      end
      FUNC_MUL: begin
        n = amag * bmag; d = 128'(o.ad) * 128'(o.bd); neg = o.an ^ o.bn;
      end
      FUNC_DIV: begin
        n = amag * 128'(o.bd); d = bmag * 128'(o.ad); neg = o.an ^ o.bn;
      end
      default: begin
        n = amag; d = 128'(o.ad); neg = o.an;
      end
    endcase
    p = n;
    q = d;
    while (q != 0) begin
      t = p % q; p = q; q = t;
    end
    n = n / p;
    d = d / p;
    whl = n / d;
    if ((whl >> FIELD_BITS) != 0 || (d >> FIELD_BITS) != 0) begin
      r.st = ST_OVF;
      return r;
    end
    t = n % d;
    r.neg = neg;
    r.whl = whl[FIELD_BITS-1:0];
    r.num = t[FIELD_BITS-1:0];
    r.den = d[FIELD_BITS-1:0];
    r.st  = ST_OK;
    return r;
  endfunction

  function automatic row_t mk(logic [2:0] f, logic an, logic [31:0] aw, ai, ad,
                              logic bn, logic [31:0] bw, bi, bd, bit typed = 0,
                              res_t ans = '0);
    row_t w;
    w.op = '{f, an, aw, ai, ad, bn, bw, bi, bd};
    w.typed = typed;
    w.ans = ans;
    return w;
  endfunction

  // small numbers mostly, so the fractions stay meaningful, with extremes mixed in
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return MAXW;
      3: return $urandom_range(1, 15);
      4, 5: return $urandom_range(1, 255);
      6: return $urandom_range(1, 65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_denom();
    if ($urandom_range(0, 39) == 0) return 32'd0;
    return (pick_word() | 32'd0) == 0 ? 32'd7 : pick_word() + 32'd0;
  endfunction

  function automatic op_t random_op();
    op_t o;
    o.f  = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
    o.an = 1'($urandom_range(0, 1));
    o.aw = pick_word();
    o.ai = pick_word();
    o.ad = pick_denom();
    o.bn = 1'($urandom_range(0, 1));
    o.bw = pick_word();
    o.bi = pick_word();
    o.bd = pick_denom();
    // a proper fraction most of the time
    if (o.ad != 0 && $urandom_range(0, 2) != 0) o.ai = o.ai % o.ad;
    if (o.bd != 0 && $urandom_range(0, 2) != 0) o.bi = o.bi % o.bd;
    return o;
  endfunction

  // Offer one transaction and wait for it to be taken; valid stays high.
  task automatic offer(op_t o, bit typed, res_t ans);
    in_valid   <= 1'b1;
    func       <= o.f;
    a_negative <= o.an;
    a_whole    <= o.aw;
    a_numer    <= o.ai;
    a_denom    <= o.ad;
    b_negative <= o.bn;
    b_whole    <= o.bw;
    b_numer    <= o.bi;
    b_denom    <= o.bd;
    do @(posedge clk); while (in_stall);
    results_due.push_back(typed ? ans : rational_result(o));
  endtask

  // Sender gap between transactions, now and then.
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none when calm.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("result with nothing outstanding");
          fails++;
        end else begin
          want = results_due.pop_front();
          if (r_negative !== want.neg) begin
            $error("r_negative: expected %0d, got %0d", want.neg, r_negative); fails++;
          end
          if (r_whole !== want.whl) begin
            $error("r_whole: expected %0d, got %0d", want.whl, r_whole); fails++;
          end
          if (r_numer !== want.num) begin
            $error("r_numer: expected %0d, got %0d", want.num, r_numer); fails++;
          end
          if (r_denom !== want.den) begin
            $error("r_denom: expected %0d, got %0d", want.den, r_denom); fails++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status); fails++;
          end
        end
      end
    end
  end

  initial begin
    row_t plan[$];
    op_t  o;
    res_t z;
    z = '0;
    // directed rows: typed answers only where they are plain to see
    plan.push_back(mk(FUNC_NORM, 0, 0, 0, 1, 0, 0, 0, 0, 1, '{0, 0, 0, 1, ST_OK}));
    plan.push_back(mk(FUNC_NORM, 1, 3, 5, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, ST_DIV0}));
    plan.push_back(mk(FUNC_ADD, 0, 1, 1, 2, 1, 1, 1, 0, 1, '{0, 0, 0, 0, ST_DIV0}));
    plan.push_back(mk(FUNC_SUB, 1, 1, 1, 2, 0, 1, 1, 0, 1, '{0, 0, 0, 0, ST_DIV0}));
    plan.push_back(mk(FUNC_MUL, 0, 1, 1, 2, 0, 1, 1, 0, 1, '{0, 0, 0, 0, ST_DIV0}));
    plan.push_back(mk(FUNC_DIV, 0, 4, 1, 3, 1, 0, 0, 5, 1, '{0, 0, 0, 0, ST_DIV0}));
    plan.push_back(mk(FUNC_MUL, 0, MAXW, 0, 1, 1, MAXW, 0, 1, 1, '{0, 0, 0, 0, ST_OVF}));
    plan.push_back(mk(FUNC_NORM, 1, MAXW, MAXW, MAXW, 0, 0, 0, 0, 1,
                      '{0, 0, 0, 0, ST_OVF}));
    plan.push_back(mk(FUNC_NORM, 1, 3, 5, 2, 0, 0, 0, 0, 1, '{1, 5, 1, 2, ST_OK}));
    plan.push_back(mk(FUNC_NORM, 0, 0, MAXW, 1, 1, 9, 9, 9, 1, '{0, MAXW, 0, 1, ST_OK}));
    plan.push_back(mk(FUNC_SUB, 1, 2, 1, 3, 1, 2, 1, 3, 1, '{0, 0, 0, 1, ST_OK}));
    plan.push_back(mk(FUNC_ADD, 1, 2, 1, 3, 0, 2, 2, 6, 1, '{0, 0, 0, 1, ST_OK}));
    plan.push_back(mk(FUNC_MUL, 1, 0, 0, 7, 0, 1, 0, 1, 1, '{1, 0, 0, 1, ST_OK}));
    plan.push_back(mk(FUNC_DIV, 0, 0, 0, 3, 1, 2, 0, 1, 1, '{1, 0, 0, 1, ST_OK}));
    plan.push_back(mk(3'd5, 0, 7, 0, 1, 1, 0, 0, 0, 1, '{0, 7, 0, 1, ST_OK}));
    plan.push_back(mk(3'd6, 1, 1, 2, 4, 0, 0, 0, 0, 1, '{1, 1, 1, 2, ST_OK}));
    plan.push_back(mk(3'd7, 0, 0, 6, 3, 1, 5, 5, 0, 1, '{0, 2, 0, 1, ST_OK}));
    plan.push_back(mk(FUNC_ADD, 0, 0, 1, MAXW, 0, 0, 1, MAXW - 1));
    plan.push_back(mk(FUNC_SUB, 0, MAXW, MAXW - 1, MAXW, 1, MAXW, 1, 2));
    plan.push_back(mk(FUNC_MUL, 1, 12345, 77, 1000, 1, 3, 2, 7));
    plan.push_back(mk(FUNC_DIV, 1, MAXW, 0, 1, 0, 0, 1, MAXW));
    plan.push_back(mk(FUNC_DIV, 0, 0, 1, MAXW, 0, MAXW, 0, 1));
    plan.push_back(mk(FUNC_ADD, 1, 32'h5555_5555, 32'hAAAA_AAAA, MAXW,
                      0, 32'hAAAA_AAAA, 32'h5555_5555, MAXW));
    plan.push_back(mk(FUNC_SUB, 0, 10, 3, 4, 0, 20, 1, 4));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      offer(plan[i].op, plan[i].typed, plan[i].ans);
      maybe_gap();
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == 300) hold_req = 1'b1;  // queue fills behind the long hold-off
      if (k == 700) begin
        // sender stands back until the block has drained
        in_valid <= 1'b0;
        wait (results_due.size() == 0);
        @(posedge clk);
      end
      if (k == N_RANDOM - N_CALM) calm = 1'b1;
      o = random_op();
      offer(o, 1'b0, z);
      maybe_gap();
    end
    in_valid <= 1'b0;

    wait (results_due.size() == 0);
    repeat (700) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rmna_pkg.sv
src/rmna_front.sv
src/rmna_back.sv
src/rational_mixed_number_alu_top.sv
tb/tb.sv
